// ===== sv/pocd_pkg.sv =====
// Package: address map, table geometry and field widths of the offset decoder.
`timescale 1ns / 1ps
package pocd_pkg;

  // Field widths
  localparam int ADDR_W   = 10;
  localparam int WORD_W   = 16;
  localparam int INDEX_W  = 10;
  localparam int OFFSET_W = 22;
  localparam int SHIFT_W  = 4;
  localparam int NIB_W    = 4;
  localparam int REM_W    = 6;

  // Pixel array geometry
  localparam int ROWS      = 24;
  localparam int COLUMNS   = 32;
  localparam int PIXELS    = ROWS * COLUMNS;
  localparam int NIB_PER_W = WORD_W / NIB_W;
  localparam int NSEL_W    = $clog2(NIB_PER_W);
  localparam int COL_IDX_W = $clog2(COLUMNS);
  localparam int ROW_IDX_W = $clog2(ROWS);
  localparam int ROW_WORDS = ROWS / NIB_PER_W;
  localparam int COL_WORDS = COLUMNS / NIB_PER_W;
  localparam int ROW_WA_W  = ROW_IDX_W - NSEL_W;
  localparam int COL_WA_W  = COL_IDX_W - NSEL_W;

  // Calibration address map
  localparam logic [ADDR_W-1:0] ADDR_SHIFTS     = 10'h010;
  localparam logic [ADDR_W-1:0] ADDR_REFERENCE  = 10'h011;
  localparam logic [ADDR_W-1:0] ADDR_ROW_BASE   = 10'h012;
  localparam logic [ADDR_W-1:0] ADDR_COL_BASE   = 10'h018;
  localparam logic [ADDR_W-1:0] ADDR_COL_END    = ADDR_COL_BASE + ADDR_W'(COL_WORDS);
  localparam logic [ADDR_W-1:0] ADDR_PIXEL_BASE = 10'h040;
  localparam logic [ADDR_W-1:0] ADDR_PIXEL_END  = ADDR_PIXEL_BASE + ADDR_W'(PIXELS);

endpackage

// ===== sv/pocd_if.sv =====
// Interfaces: calibration word channel and pixel offset result channel.
`timescale 1ns / 1ps
interface pocd_in_if
  import pocd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] word_address;
  logic [WORD_W-1:0] word_value;

  modport source (output valid, output word_address, output word_value, input ready);
  modport sink   (input valid, input word_address, input word_value, output ready);
endinterface

interface pocd_out_if
  import pocd_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic        [INDEX_W-1:0]  pixel_index;
  logic signed [OFFSET_W-1:0] pixel_offset;

  modport source (output valid, output pixel_index, output pixel_offset, input ready);
  modport sink   (input valid, input pixel_index, input pixel_offset, output ready);
endinterface

// ===== sv/pixel_offset_calibration_decode.sv =====
// Top level: decodes pixel offsets from a streamed calibration memory dump.
// Pipeline: a pixel word is captured in the read stage along with its memory reads,
//   then its result moves to the output register, which holds it while the sink stalls.
// Throughput: one word per cycle while the sink does not stall; the correction memories take
//   one read and one write per cycle, and only one word enters per cycle.
// Reset: clears the pipeline valids, the shift amounts and the reference.
//   Row and column correction memories are not cleared; write them first.
`timescale 1ns / 1ps
module pixel_offset_calibration_decode
  import pocd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  pocd_in_if.sink           in_chan,
  pocd_out_if.source        out_chan
);

  // Header registers
  logic        [SHIFT_W-1:0] row_shift_r, col_shift_r, rem_shift_r;
  logic signed [WORD_W-1:0]  reference_r;

  // Correction memories, one calibration word per entry
  logic [WORD_W-1:0] row_mem [ROW_WORDS];
  logic [WORD_W-1:0] col_mem [COL_WORDS];

  // Read stage
  logic                       s1_valid_r;
  logic        [INDEX_W-1:0]  s1_index_r;
  logic        [REM_W-1:0]    s1_rem_r;
  logic signed [WORD_W-1:0]   s1_ref_r;
  logic        [SHIFT_W-1:0]  s1_rshift_r, s1_cshift_r, s1_pshift_r;
  logic        [NSEL_W-1:0]   s1_rsel_r, s1_csel_r;
  logic        [WORD_W-1:0]   row_rd_r, col_rd_r;

  // Output register
  logic                       out_valid_r;
  logic        [INDEX_W-1:0]  out_index_r;
  logic signed [OFFSET_W-1:0] out_offset_r;
  logic signed [OFFSET_W-1:0] offset_nxt;

  logic                  in_fire, s1_adv;
  logic                  is_pixel, is_row, is_col;
  logic [ADDR_W-1:0]     pix_num, row_off, col_off;
  logic [ROW_IDX_W-1:0]  row_idx;
  logic [COL_IDX_W-1:0]  col_idx;

  // Handshake and address decode
  assign s1_adv        = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign is_pixel = (in_chan.word_address >= ADDR_PIXEL_BASE) &&
                    (in_chan.word_address <  ADDR_PIXEL_END);
  assign is_row   = (in_chan.word_address >= ADDR_ROW_BASE) &&
                    (in_chan.word_address <  ADDR_COL_BASE);
  assign is_col   = (in_chan.word_address >= ADDR_COL_BASE) &&
                    (in_chan.word_address <  ADDR_COL_END);
  assign pix_num  = in_chan.word_address - ADDR_PIXEL_BASE;
  assign row_off  = in_chan.word_address - ADDR_ROW_BASE;
  assign col_off  = in_chan.word_address - ADDR_COL_BASE;
  assign col_idx  = pix_num[COL_IDX_W-1:0];
  assign row_idx  = pix_num[COL_IDX_W +: ROW_IDX_W];

  // Update header registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_shift_r <= '0;
      col_shift_r <= '0;
      rem_shift_r <= '0;
      reference_r <= '0;
    end else if (in_fire) begin
      if (in_chan.word_address == ADDR_SHIFTS) begin
        row_shift_r <= in_chan.word_value[11:8];
        col_shift_r <= in_chan.word_value[7:4];
        rem_shift_r <= in_chan.word_value[3:0];
      end
      if (in_chan.word_address == ADDR_REFERENCE) begin
        reference_r <= in_chan.word_value;
      end
    end
  end

  // Write correction words; read both memories for a pixel word.
  // One word per cycle, so a write always lands before a later read.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (is_row) begin
        row_mem[row_off[ROW_WA_W-1:0]] <= in_chan.word_value;
      end
      if (is_col) begin
        col_mem[col_off[COL_WA_W-1:0]] <= in_chan.word_value;
      end
      row_rd_r <= row_mem[row_idx[ROW_IDX_W-1:NSEL_W]];
      col_rd_r <= col_mem[col_idx[COL_IDX_W-1:NSEL_W]];
    end
  end

  // Read stage: capture pixel context alongside the memory reads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= is_pixel;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_index_r  <= pix_num[INDEX_W-1:0];
      s1_rem_r    <= in_chan.word_value[WORD_W-1 -: REM_W];
      s1_ref_r    <= reference_r;
      s1_rshift_r <= row_shift_r;
      s1_cshift_r <= col_shift_r;
      s1_pshift_r <= rem_shift_r;
      s1_rsel_r   <= row_idx[NSEL_W-1:0];
      s1_csel_r   <= col_idx[NSEL_W-1:0];
    end
  end

  // Select nibbles, scale and sum at full width
  always_comb begin
    logic        [NIB_W-1:0]    row_nib, col_nib;
    logic signed [OFFSET_W-1:0] row_term, col_term, rem_term, ref_term;
    row_nib  = row_rd_r[{s1_rsel_r, 2'b00} +: NIB_W];
    col_nib  = col_rd_r[{s1_csel_r, 2'b00} +: NIB_W];
    row_term = {{(OFFSET_W-NIB_W){row_nib[NIB_W-1]}}, row_nib};
    col_term = {{(OFFSET_W-NIB_W){col_nib[NIB_W-1]}}, col_nib};
    rem_term = {{(OFFSET_W-REM_W){s1_rem_r[REM_W-1]}}, s1_rem_r};
    ref_term = {{(OFFSET_W-WORD_W){s1_ref_r[WORD_W-1]}}, s1_ref_r};
    offset_nxt = ref_term + (row_term <<< s1_rshift_r) + (col_term <<< s1_cshift_r)
               + (rem_term <<< s1_pshift_r);
  end

  // Output register: hold while the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_index_r  <= s1_index_r;
      out_offset_r <= offset_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.pixel_index  = out_index_r;
  assign out_chan.pixel_offset = out_offset_r;

endmodule

// ===== sv/pocd_checker.sv =====
// Checker: port-level properties of the offset decoder, bound to the top level.
`timescale 1ns / 1ps
module pocd_checker
  import pocd_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [INDEX_W-1:0]  out_pixel_index,
  input logic [OFFSET_W-1:0] out_pixel_offset
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel_index) && $stable(out_pixel_offset))
    else $error("result payload changed while stalled");

  // Pixel index stays within the array
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pixel_index < INDEX_W'(PIXELS))
    else $error("pixel index out of range");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind pixel_offset_calibration_decode pocd_checker u_pocd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_pixel_index  (out_chan.pixel_index),
  .out_pixel_offset (out_chan.pixel_offset)
);

// ===== tb/sv/pixel_offset_calibration_decode_test.sv =====
// Testbench: streams calibration dumps into the pixel offset decoder and checks every result.
`timescale 1ns / 1ps
module pixel_offset_calibration_decode_test;
  import pocd_pkg::*;

  localparam int RANDOM_WORDS = 1300;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_START   = 1500;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] value;
  } cal_word_t;

  typedef struct packed {
    logic        [INDEX_W-1:0]  index;
    logic signed [OFFSET_W-1:0] offset;
  } pixel_result_t;

  logic clk;
  logic rst_n;

  pocd_in_if  in_chan ();
  pocd_out_if out_chan ();

  pixel_offset_calibration_decode u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Words waiting to be sent and offsets waiting to come back
  cal_word_t     dump_words[$];
  pixel_result_t offsets_due[$];

  // Decoder state as the predictor sees it
  logic signed [WORD_W-1:0]  cal_reference = '0;
  logic        [SHIFT_W-1:0] cal_row_shift = '0;
  logic        [SHIFT_W-1:0] cal_col_shift = '0;
  logic        [SHIFT_W-1:0] cal_rem_shift = '0;
  logic signed [NIB_W-1:0]   row_nibbles[ROWS] = '{default: '0};
  logic signed [NIB_W-1:0]   col_nibbles[COLUMNS] = '{default: '0};

  int        words_total;
  int        words_accepted = 0;
  int        offsets_checked = 0;
  int        dumps_sent;
  int        failures = 0;
  int        cycles = 0;
  int        tx_idle;
  bit        tx_calm;
  int        rx_idle;
  int        rx_hold;
  bit        rx_calm;
  cal_word_t tx_word;

  // Clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, none at all in a calm stretch
  function automatic int idle_len(bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Shift amount biased toward both extremes
  function automatic logic [SHIFT_W-1:0] pick_shift();
    int roll;
    roll = $urandom_range(0, 3);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return SHIFT_W'($urandom);
  endfunction

  task automatic queue_word(input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] value);
    cal_word_t w;
    w.addr  = addr;
    w.value = value;
    dump_words.push_back(w);
    words_total++;
  endtask

  // Update the decoder state for one transferred word; queue the offset a pixel word yields
  function automatic void decode_word(cal_word_t w);
    int                      base;
    int                      p;
    int                      sum;
    logic signed [REM_W-1:0] rem;
    pixel_result_t           r;
    if (w.addr == ADDR_SHIFTS) begin
      cal_row_shift = w.value[11:8];
      cal_col_shift = w.value[7:4];
      cal_rem_shift = w.value[3:0];
    end else if (w.addr == ADDR_REFERENCE) begin
      cal_reference = w.value;
    end else if (w.addr >= ADDR_ROW_BASE && w.addr < ADDR_COL_BASE) begin
      base = int'(w.addr - ADDR_ROW_BASE) * NIB_PER_W;
      for (int k = 0; k < NIB_PER_W; k++) row_nibbles[base + k] = w.value[NIB_W*k +: NIB_W];
    end else if (w.addr >= ADDR_COL_BASE && w.addr < ADDR_COL_END) begin
      base = int'(w.addr - ADDR_COL_BASE) * NIB_PER_W;
      for (int k = 0; k < NIB_PER_W; k++) col_nibbles[base + k] = w.value[NIB_W*k +: NIB_W];
    end else if (w.addr >= ADDR_PIXEL_BASE && w.addr < ADDR_PIXEL_END) begin
      p   = int'(w.addr - ADDR_PIXEL_BASE);
      rem = w.value[15:10];
      sum = int'(cal_reference)
          + int'(row_nibbles[p / COLUMNS]) * (1 << cal_row_shift)
          + int'(col_nibbles[p % COLUMNS]) * (1 << cal_col_shift)
          + int'(rem) * (1 << cal_rem_shift);
      r.index  = INDEX_W'(p);
      r.offset = sum[OFFSET_W-1:0];
      offsets_due.push_back(r);
    end
  endfunction

  // Cycle count and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d offsets still due", cycles, offsets_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Driver: hold a word until transferred, then idle a random gap and load the next
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid        <= 1'b0;
      in_chan.word_address <= '0;
      in_chan.word_value   <= '0;
      tx_idle              = 0;
      tx_calm              = 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        decode_word(tx_word);
        words_accepted++;
        if ($urandom_range(0, 79) == 0) tx_calm = !tx_calm;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (tx_idle > 0) begin
          tx_idle--;
          in_chan.valid <= 1'b0;
        end else if (dump_words.size() > 0) begin
          tx_word = dump_words.pop_front();
          in_chan.valid        <= 1'b1;
          in_chan.word_address <= tx_word.addr;
          in_chan.word_value   <= tx_word.value;
          tx_idle = idle_len(tx_calm);
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls plus one long hold-off while words keep coming
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      rx_idle        = 0;
      rx_hold        = 0;
      rx_calm        = 1'b0;
    end else begin
      if ($urandom_range(0, 79) == 0) rx_calm = !rx_calm;
      if (cycles == HOLD_START) rx_hold = HOLD_CYCLES;
      if (rx_hold > 0) begin
        rx_hold--;
        out_chan.ready <= 1'b0;
      end else if (rx_idle > 0) begin
        rx_idle--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        rx_idle = idle_len(rx_calm);
      end
    end
  end

  // Monitor: compare each transferred result with the oldest offset due
  always @(posedge clk) begin
    pixel_result_t due;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (offsets_due.size() == 0) begin
        $error("unexpected result: pixel_index %0d pixel_offset %0d",
               out_chan.pixel_index, out_chan.pixel_offset);
        failures++;
      end else begin
        due = offsets_due.pop_front();
        offsets_checked++;
        if (out_chan.pixel_index !== due.index) begin
          $error("pixel_index: expected %0d, actual %0d", due.index, out_chan.pixel_index);
          failures++;
        end
        if (out_chan.pixel_offset !== due.offset) begin
          $error("pixel_offset (pixel %0d): expected %0d, actual %0d",
                 due.index, due.offset, out_chan.pixel_offset);
          failures++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int   counted;
    int   start;
    int   len;
    int   sel;
    logic [ADDR_W-1:0] addr;

    rst_n          = 1'b0;
    words_total    = 0;
    dumps_sent     = 0;

    // Directed: largest shifts, most negative terms, then most positive terms
    queue_word(ADDR_SHIFTS, 16'hFFFF);
    queue_word(ADDR_REFERENCE, 16'h8000);
    for (int k = 0; k < ROW_WORDS; k++) queue_word(ADDR_W'(ADDR_ROW_BASE + k), 16'h8888);
    for (int k = 0; k < COL_WORDS; k++) queue_word(ADDR_W'(ADDR_COL_BASE + k), 16'h8888);
    queue_word(ADDR_PIXEL_BASE, 16'h83FF);
    queue_word(ADDR_REFERENCE, 16'h7FFF);
    queue_word(ADDR_W'(ADDR_ROW_BASE + ROW_WORDS - 1), 16'h7777);
    queue_word(ADDR_W'(ADDR_COL_BASE + COL_WORDS - 1), 16'h7777);
    queue_word(ADDR_W'(ADDR_PIXEL_END - 1), 16'h7C00);
    // Zero shifts, unused addresses, ignored low pixel bits
    queue_word(ADDR_SHIFTS, 16'h0000);
    queue_word(10'h000, 16'hFFFF);
    queue_word(10'h03F, 16'hFFFF);
    queue_word(10'h340, 16'hFFFF);
    queue_word(10'h3FF, 16'hFFFF);
    queue_word(10'h200, 16'h5A3C);
    queue_word(ADDR_W'(ADDR_PIXEL_BASE + COLUMNS - 1), 16'hFFFF);

    // Random: mostly whole headers followed by a run of pixels, plus noise and rewrites
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        queue_word(ADDR_SHIFTS, {4'($urandom), pick_shift(), pick_shift(), pick_shift()});
        queue_word(ADDR_REFERENCE, WORD_W'($urandom));
        for (int k = 0; k < ROW_WORDS; k++)
          queue_word(ADDR_W'(ADDR_ROW_BASE + k), WORD_W'($urandom));
        for (int k = 0; k < COL_WORDS; k++)
          queue_word(ADDR_W'(ADDR_COL_BASE + k), WORD_W'($urandom));
        counted += 2 + ROW_WORDS + COL_WORDS;
        start = $urandom_range(0, PIXELS - 1);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160) : $urandom_range(1, 40);
        for (int n = 0; n < len && start + n < PIXELS; n++) begin
          queue_word(ADDR_W'(ADDR_PIXEL_BASE + start + n), WORD_W'($urandom));
          counted++;
        end
        dumps_sent++;
      end else if (sel < 88) begin
        case ($urandom_range(0, 2))
          0:       addr = ADDR_W'($urandom_range(16'h000, 16'h00F));
          1:       addr = ADDR_W'($urandom_range(16'h020, 16'h03F));
          default: addr = ADDR_W'($urandom_range(16'h340, 16'h3FF));
        endcase
        queue_word(addr, WORD_W'($urandom));
      end else begin
        // Out of order: replace one header word, then scattered pixels
        addr = ADDR_W'(ADDR_SHIFTS + $urandom_range(0, 15));
        if (addr == ADDR_SHIFTS)
          queue_word(addr, {4'($urandom), pick_shift(), pick_shift(), pick_shift()});
        else
          queue_word(addr, WORD_W'($urandom));
        counted++;
        len = $urandom_range(1, 4);
        for (int n = 0; n < len; n++) begin
          queue_word(ADDR_W'(ADDR_PIXEL_BASE + $urandom_range(0, PIXELS - 1)),
                     WORD_W'($urandom));
          counted++;
        end
      end
    end

    // Release reset, then wait for every word and every offset
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (words_accepted < words_total) @(posedge clk);
    while (offsets_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d calibration words (%0d full header dumps) in %0d cycles.",
             words_total, dumps_sent, cycles);
    $display("Checked %0d pixel offsets under random stalls and one long output hold-off.",
             offsets_checked);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
